### sv/rtdc_pkg.sv
// Shared types, constants and helper functions of the RTD code-to-temperature block.
// Used by every module of the block; depends on nothing else.
package rtdc_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Radicand numerator: 1759246 * 2^23 - 577680 * (code - 2^23), then * 2^12 / 3125.
    localparam logic [19:0] MUL_R = 20'd577680;
    localparam logic [45:0] RADIC_BASE = 46'(1759246) << 23;
    localparam logic [12:0] DIV_X = 13'd3125;

    // Temperature: floor((195400 * 2^20 + 118784 - 50000 * s) / (29 * 2^13)).
    localparam logic [15:0] MUL_S = 16'd50000;
    localparam logic [39:0] Q_BASE = (40'(195400) << 20) + 40'(118784);
    localparam logic [12:0] DIV_T = 13'd29;
    localparam logic [26:0] U_OFF = 27'(29) << 19;
    localparam logic [19:0] T_BIAS = 20'h80000;

    localparam logic [44:0] SQRT_TOP = 45'(1) << 44;

    localparam logic [2:0] DIV_LAST_X = 3'd7;
    localparam logic [2:0] DIV_LAST_T = 3'd3;

    localparam logic [23:0] EXC_CH0 = 24'h0020B4;
    localparam logic [23:0] EXC_OTHER = 24'h0004B4;
    localparam logic [15:0] FIRST_CH0 = 16'h0064;
    localparam logic [15:0] FIRST_OTHER = 16'h8064;
    localparam logic [15:0] SECOND_CH0 = 16'h80C7;
    localparam logic [15:0] SECOND_OTHER = 16'h00C7;

    typedef struct packed {
        logic [23:0] adc_code;
        logic [3:0]  channel_tag;
        logic [3:0]  result_base;
    } in_t;

    typedef struct packed {
        logic signed [18:0] temperature_q8;
        logic [3:0]         channel_out;
        logic [4:0]         result_index;
        logic [31:0]        sample_total;
        logic [23:0]        excitation_word;
        logic [15:0]        first_channel_word;
        logic [15:0]        second_channel_word;
    } out_t;

    typedef struct packed {
        logic [23:0] code;
        logic [3:0]  channel;
        logic [4:0]  index;
        logic [31:0] total;
        logic        first_ch;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV1,
        B_SQRT,
        B_FIN,
        B_DIV2,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [12:0] rem;
        logic [7:0]  quo;
    } div_res_t;

    // Eight restoring division steps against a constant divisor below 2^13.
    function automatic div_res_t div_step8(input logic [12:0] rem_in, input logic [7:0] bits,
                                           input logic [12:0] divisor);
        logic [13:0] r;
        div_res_t    res;
        r = {1'b0, rem_in};
        res.quo = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[12:0], bits[i]};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
                res.quo[i] = 1'b1;
            end
        end
        res.rem = r[12:0];
        return res;
    endfunction

endpackage

### sv/rtd_adc_code_to_temperature_top.sv
// Top level of the RTD code-to-temperature block: front end, job queue and back end.
// Depends on rtdc_pkg, rtdc_front, rtdc_queue and rtdc_back.
//
//   Channel   Handshake      Payload              Direction
//   request   push / full    rtdc_pkg::in_t       into the block
//   result    empty / pop    rtdc_pkg::out_t      out of the block
//
// Each request passes through the back end as setup, the radicand division (eight
// quotient bits a cycle), the bit-serial square root, the final division and the
// hand-off. The back end works on one request at a time; the queue holds two more,
// and full rises when both queue slots are taken.
// Reset clears the sample counters, the queue pointers and count and the result valid flag at once.
// A result that is not popped stalls the back end, never the front end until the queue fills.
module rtd_adc_code_to_temperature_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  rtdc_pkg::in_t    request,
    output logic             empty,
    input  logic             pop,
    output rtdc_pkg::out_t   result
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    rtdc_pkg::job_t  q_in;
    rtdc_pkg::job_t  q_out;

    rtdc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    rtdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .entry_out (q_out)
    );

    rtdc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_entry (q_out),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

`ifndef SYNTHESIS
    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty)
        else $error("job queue reports full and empty together");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && q_empty) |=> !q_empty)
        else $error("accepted request did not reach the job queue");

    a_words_match: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.channel_out == 4'd0) ==
                    (result.excitation_word == rtdc_pkg::EXC_CH0)))
        else $error("excitation word does not match result channel");

    a_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ({1'b0, result.channel_out} >= 5'(rtdc_pkg::CHANNELS)))
            |-> (result.sample_total == 32'd0))
        else $error("sample total given for a channel without a counter");
`endif

endmodule

### sv/rtdc_front.sv
// Front end: accepts requests, keeps the per-channel sample counters and classifies
// each request into a job for the back end. Depends on rtdc_pkg.
module rtdc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  rtdc_pkg::in_t    request,
    input  logic             q_full,
    output logic             q_push,
    output rtdc_pkg::job_t   q_entry
);

    logic [31:0]                  cnt_reg [rtdc_pkg::CHANNELS];
    logic [31:0]                  cnt_next [rtdc_pkg::CHANNELS];
    logic [rtdc_pkg::CH_W-1:0]    idx;
    logic                         ch_ok;
    logic                         accept;
    logic [31:0]                  total;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;
    assign idx    = request.channel_tag[rtdc_pkg::CH_W-1:0];
    assign ch_ok  = {1'b0, request.channel_tag} < 5'(rtdc_pkg::CHANNELS);

    always_comb
    begin
        cnt_next = cnt_reg;
        total    = '0;
        if (ch_ok)
        begin
            total = cnt_reg[idx] + 32'd1;
            if (accept)
            begin
                cnt_next[idx] = total;
            end
        end
    end

    always_comb
    begin
        q_entry.code     = request.adc_code;
        q_entry.channel  = request.channel_tag;
        q_entry.index    = 5'(request.channel_tag) + 5'(request.result_base);
        q_entry.total    = total;
        q_entry.first_ch = (request.channel_tag == 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rtdc_pkg::CHANNELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/rtdc_queue.sv
// Short job queue between the front and back ends, built from registers.
// Depends on rtdc_pkg.
module rtdc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rtdc_pkg::job_t   entry_in,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output rtdc_pkg::job_t   entry_out
);

    rtdc_pkg::job_t              slot_reg [rtdc_pkg::QDEPTH];
    logic [rtdc_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [rtdc_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [rtdc_pkg::QPTR_W:0]   cnt_reg, cnt_next;
    logic                        do_push;
    logic                        do_pop;

    assign full      = (cnt_reg == (rtdc_pkg::QPTR_W + 1)'(rtdc_pkg::QDEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign entry_out = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == rtdc_pkg::QPTR_W'(rtdc_pkg::QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == rtdc_pkg::QPTR_W'(rtdc_pkg::QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= entry_in;
        end
    end

endmodule

### sv/rtdc_back.sv
// Back end: converts one queued job to temperature with a shared constant divider
// and a bit-serial square root, and holds the finished result. Depends on rtdc_pkg.
module rtdc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  rtdc_pkg::job_t   q_entry,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output rtdc_pkg::out_t   result
);

    rtdc_pkg::back_state_t state_reg, state_next;
    rtdc_pkg::job_t        job_reg, job_next;
    rtdc_pkg::out_t        out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [63:0]           num_reg, num_next;
    logic [63:0]           quo_reg, quo_next;
    logic [12:0]           rem_reg, rem_next;
    logic [44:0]           v_reg, v_next;
    logic [44:0]           root_reg, root_next;
    logic [44:0]           bit_reg, bit_next;

    logic signed [23:0]    d;
    logic signed [44:0]    prod_a;
    logic [45:0]           a_val;
    rtdc_pkg::div_res_t    div_r;
    logic [63:0]           quo_shift;
    logic [45:0]           trial;
    logic [38:0]           prod_s;
    logic signed [39:0]    q_val;
    logic signed [26:0]    qs;
    logic [26:0]           u_val;
    logic [19:0]           t_val;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        // Offset binary to two's complement is an inversion of the top bit.
        d         = {~job_reg.code[23], job_reg.code[22:0]};
        prod_a    = $signed({1'b0, rtdc_pkg::MUL_R}) * d;
        a_val     = rtdc_pkg::RADIC_BASE - {prod_a[44], prod_a};
        div_r     = rtdc_pkg::div_step8(rem_reg, num_reg[63:56],
                        (state_reg == rtdc_pkg::B_DIV1) ? rtdc_pkg::DIV_X : rtdc_pkg::DIV_T);
        quo_shift = {quo_reg[55:0], div_r.quo};
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        prod_s    = root_reg[22:0] * rtdc_pkg::MUL_S;
        q_val     = rtdc_pkg::Q_BASE - {1'b0, prod_s};
        qs        = 27'(q_val >>> 13);
        // The bias keeps the last division nonnegative; it is removed from the quotient.
        u_val     = qs + rtdc_pkg::U_OFF;
        t_val     = quo_reg[19:0] - rtdc_pkg::T_BIAS;
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        v_next         = v_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        q_pop          = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rtdc_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_entry;
                    state_next = rtdc_pkg::B_MUL;
                end
            end
            rtdc_pkg::B_MUL:
            begin
                num_next   = {7'b0, a_val[44:0], 12'b0};
                quo_next   = '0;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = rtdc_pkg::B_DIV1;
            end
            rtdc_pkg::B_DIV1:
            begin
                num_next = {num_reg[55:0], 8'b0};
                quo_next = quo_shift;
                rem_next = div_r.rem;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == rtdc_pkg::DIV_LAST_X)
                begin
                    v_next     = quo_shift[44:0];
                    root_next  = '0;
                    bit_next   = rtdc_pkg::SQRT_TOP;
                    state_next = rtdc_pkg::B_SQRT;
                end
            end
            rtdc_pkg::B_SQRT:
            begin
                if ({1'b0, v_reg} >= trial)
                begin
                    v_next    = v_reg - trial[44:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = rtdc_pkg::B_FIN;
                end
            end
            rtdc_pkg::B_FIN:
            begin
                num_next   = {7'b0, u_val[24:0], 32'b0};
                quo_next   = '0;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = rtdc_pkg::B_DIV2;
            end
            rtdc_pkg::B_DIV2:
            begin
                num_next = {num_reg[55:0], 8'b0};
                quo_next = quo_shift;
                rem_next = div_r.rem;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == rtdc_pkg::DIV_LAST_T)
                begin
                    state_next = rtdc_pkg::B_DONE;
                end
            end
            rtdc_pkg::B_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.temperature_q8 = $signed(t_val[18:0]);
                    out_next.channel_out    = job_reg.channel;
                    out_next.result_index   = job_reg.index;
                    out_next.sample_total   = job_reg.total;
                    if (job_reg.first_ch)
                    begin
                        out_next.excitation_word     = rtdc_pkg::EXC_CH0;
                        out_next.first_channel_word  = rtdc_pkg::FIRST_CH0;
                        out_next.second_channel_word = rtdc_pkg::SECOND_CH0;
                    end
                    else
                    begin
                        out_next.excitation_word     = rtdc_pkg::EXC_OTHER;
                        out_next.first_channel_word  = rtdc_pkg::FIRST_OTHER;
                        out_next.second_channel_word = rtdc_pkg::SECOND_OTHER;
                    end
                    out_valid_next = 1'b1;
                    state_next     = rtdc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = rtdc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtdc_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        out_reg  <= out_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

endmodule

### sim/rtd_adc_code_to_temperature_top_tb.sv
// Testbench for the RTD code-to-temperature block: directed and random ADC codes,
// each result checked against a fixed-point inverse Callendar-Van Dusen predictor.
// Depends on rtdc_pkg and rtd_adc_code_to_temperature_top.
`timescale 1ns / 100ps

module rtd_adc_code_to_temperature_top_tb;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 100;

    localparam longint CODE_ZERO = 64'sd8388608;
    localparam longint ROOT_DEN = 64'sd118784;
    localparam longint TEMP_MAX = 64'sd262143;
    localparam longint TEMP_MIN = -64'sd262144;

    localparam logic [23:0] EXCITE_AFTER_CH0 = 24'h0020B4;
    localparam logic [23:0] EXCITE_AFTER_OTHER = 24'h0004B4;
    localparam logic [15:0] CH0_SETUP_AFTER_CH0 = 16'h0064;
    localparam logic [15:0] CH0_SETUP_AFTER_OTHER = 16'h8064;
    localparam logic [15:0] CH1_SETUP_AFTER_CH0 = 16'h80C7;
    localparam logic [15:0] CH1_SETUP_AFTER_OTHER = 16'h00C7;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            push = 1'b0;
    logic            pop = 1'b0;
    rtdc_pkg::in_t   request = '0;
    logic            full;
    logic            empty;
    rtdc_pkg::out_t  result;

    rtdc_pkg::in_t   codes_to_send[$];
    rtdc_pkg::out_t  readings_due[$];
    logic [31:0]     chan_samples[rtdc_pkg::CHANNELS];
    int              request_total = 0;
    int              requests_taken = 0;
    int              error_count = 0;
    int              cycle_count = 0;
    int              send_gap = 0;
    int              read_stall = 0;
    logic            request_taken = 1'b0;
    logic            reading_taken = 1'b0;

    rtd_adc_code_to_temperature_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always #2 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'h1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [18:0] code_to_celsius_q8(input logic [23:0] code);
        longint offset;
        longint radicand;
        longint root;
        longint numer;
        longint q;
        longint t;
        offset = longint'(code) - CODE_ZERO;
        radicand = 64'sd1759246 * (64'sd1 << 40) - 64'sd577680 * offset * 64'sd131072;
        root = longint'(int_sqrt(longint'(radicand / 64'sd100000)));
        numer = (64'sd3908 * 64'sd1048576 - 64'sd1000 * root) * 64'sd25;
        q = 2 * numer + ROOT_DEN;
        // Floor division, so negative temperatures round the same way as positive ones.
        if (q >= 0)
            t = q / (2 * ROOT_DEN);
        else
            t = -((-q + 2 * ROOT_DEN - 1) / (2 * ROOT_DEN));
        if (t > TEMP_MAX)
            t = TEMP_MAX;
        if (t < TEMP_MIN)
            t = TEMP_MIN;
        return t[18:0];
    endfunction

    function automatic rtdc_pkg::out_t predict_reading(input rtdc_pkg::in_t req);
        rtdc_pkg::out_t rd;
        rd.temperature_q8 = code_to_celsius_q8(req.adc_code);
        rd.channel_out = req.channel_tag;
        rd.result_index = 5'(req.result_base) + 5'(req.channel_tag);
        rd.sample_total = '0;
        if (int'(req.channel_tag) < rtdc_pkg::CHANNELS)
        begin
            chan_samples[req.channel_tag] = chan_samples[req.channel_tag] + 32'd1;
            rd.sample_total = chan_samples[req.channel_tag];
        end
        if (req.channel_tag == 4'd0)
        begin
            rd.excitation_word = EXCITE_AFTER_CH0;
            rd.first_channel_word = CH0_SETUP_AFTER_CH0;
            rd.second_channel_word = CH1_SETUP_AFTER_CH0;
        end
        else
        begin
            rd.excitation_word = EXCITE_AFTER_OTHER;
            rd.first_channel_word = CH0_SETUP_AFTER_OTHER;
            rd.second_channel_word = CH1_SETUP_AFTER_OTHER;
        end
        return rd;
    endfunction

    // Mostly none or short gaps, a few long ones, and a quarter of the time none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_count / 1024) % 4 == 0)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 20);
        return $urandom_range(30, 80);
    endfunction

    function automatic rtdc_pkg::in_t make_request(input logic [23:0] code,
                                                   input logic [3:0] ch,
                                                   input logic [3:0] base);
        rtdc_pkg::in_t req;
        req.adc_code = code;
        req.channel_tag = ch;
        req.result_base = base;
        return req;
    endfunction

    function automatic logic [23:0] random_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 24'($urandom);
        if (r < 80)
            return 24'(32'h800000 + $urandom_range(0, 8191) - 4096);
        if (r < 88)
            return 24'($urandom_range(0, 4095));
        if (r < 96)
            return 24'($urandom_range(24'hFFF000, 24'hFFFFFF));
        return (r < 98) ? 24'h000000 : 24'hFFFFFF;
    endfunction

    // Request side: the next request goes out after its gap once the last one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || request_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (codes_to_send.size() > 0)
            begin
                request <= codes_to_send.pop_front();
                push <= 1'b1;
                send_gap = pick_gap();
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            readings_due.push_back(predict_reading(request));
            requests_taken++;
            request_taken <= 1'b1;
        end
        else
            request_taken <= 1'b0;
    end

    // Result side: random stalls on pop.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (reading_taken)
                read_stall = pick_gap();
            if (read_stall > 0)
            begin
                read_stall--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rtdc_pkg::out_t want;
        if (rst_n && pop && !empty)
        begin
            reading_taken <= 1'b1;
            if (readings_due.size() == 0)
                flag_error("result with no request outstanding");
            else
            begin
                want = readings_due.pop_front();
                if (result.temperature_q8 !== want.temperature_q8)
                    flag_error($sformatf("temperature_q8 got %0d, expected %0d",
                                         result.temperature_q8, want.temperature_q8));
                if (result.channel_out !== want.channel_out)
                    flag_error($sformatf("channel_out got %0d, expected %0d",
                                         result.channel_out, want.channel_out));
                if (result.result_index !== want.result_index)
                    flag_error($sformatf("result_index got %0d, expected %0d",
                                         result.result_index, want.result_index));
                if (result.sample_total !== want.sample_total)
                    flag_error($sformatf("sample_total got %0d, expected %0d",
                                         result.sample_total, want.sample_total));
                if (result.excitation_word !== want.excitation_word)
                    flag_error($sformatf("excitation_word got %h, expected %h",
                                         result.excitation_word, want.excitation_word));
                if (result.first_channel_word !== want.first_channel_word)
                    flag_error($sformatf("first_channel_word got %h, expected %h",
                                         result.first_channel_word, want.first_channel_word));
                if (result.second_channel_word !== want.second_channel_word)
                    flag_error($sformatf("second_channel_word got %h, expected %h",
                                         result.second_channel_word,
                                         want.second_channel_word));
            end
        end
        else
            reading_taken <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int r;
        logic [3:0] ch;
        for (int i = 0; i < rtdc_pkg::CHANNELS; i++)
            chan_samples[i] = '0;

        // Code extremes, the zero point, both setup-word patterns and every channel.
        codes_to_send.push_back(make_request(24'h000000, 4'd0, 4'd0));
        codes_to_send.push_back(make_request(24'hFFFFFF, 4'd1, 4'd9));
        codes_to_send.push_back(make_request(24'h800000, 4'd0, 4'd9));
        codes_to_send.push_back(make_request(24'h7FFFFF, 4'd1, 4'd0));
        codes_to_send.push_back(make_request(24'h800001, 4'd0, 4'd3));
        codes_to_send.push_back(make_request(24'h000001, 4'd0, 4'd8));
        codes_to_send.push_back(make_request(24'hFFFFFE, 4'd1, 4'd1));
        codes_to_send.push_back(make_request(24'hAAAAAA, 4'd2, 4'd5));
        codes_to_send.push_back(make_request(24'h555555, 4'd15, 4'd9));
        codes_to_send.push_back(make_request(24'hFFFFFF, 4'd15, 4'd0));
        for (int c = 3; c < 15; c++)
            codes_to_send.push_back(make_request(24'($urandom), 4'(c), 4'($urandom_range(0, 9))));

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // Weighted toward the two channels the excitation scheme alternates between.
            r = $urandom_range(0, 99);
            if (r < 35)
                ch = 4'd0;
            else if (r < 70)
                ch = 4'd1;
            else
                ch = 4'($urandom_range(0, 15));
            codes_to_send.push_back(make_request(random_code(), ch, 4'($urandom_range(0, 9))));
        end
        request_total = codes_to_send.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (requests_taken == request_total);
        wait (readings_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
sv/rtdc_pkg.sv
sv/rtdc_front.sv
sv/rtdc_queue.sv
sv/rtdc_back.sv
sv/rtd_adc_code_to_temperature_top.sv
sim/rtd_adc_code_to_temperature_top_tb.sv
